// File: design/cst_pkg.sv
// Shared types, codes and defaults for the counting semaphore table.
`timescale 1ns / 1ps

package cst_pkg;

  // Default sizes
  localparam int NUM_SEMAPHORES_DEF = 16;
  localparam int QUEUE_DEPTH_DEF    = 16;
  localparam int PID_BITS_DEF       = 8;
  localparam int COUNT_BITS_DEF     = 16;

  // Fixed field widths
  localparam int PID_FIELD_W   = 8;
  localparam int COUNT_FIELD_W = 16;
  localparam int OPENERS_W     = 8;
  localparam logic [OPENERS_W-1:0] OPENERS_MAX = 8'hFF;

  // Commands
  localparam logic [1:0] CMD_OPEN  = 2'd0;
  localparam logic [1:0] CMD_CLOSE = 2'd1;
  localparam logic [1:0] CMD_WAIT  = 2'd2;
  localparam logic [1:0] CMD_POST  = 2'd3;

  // Status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BLOCKED    = 3'd1;
  localparam logic [2:0] ST_NO_SEM     = 3'd2;
  localparam logic [2:0] ST_TABLE_FULL = 3'd3;
  localparam logic [2:0] ST_QUEUE_FULL = 3'd4;

  typedef struct packed {
    logic [1:0]               command;
    logic [31:0]              sem_key;
    logic [COUNT_FIELD_W-1:0] initial_count;
    logic [PID_FIELD_W-1:0]   caller_pid;
  } req_t;

  typedef struct packed {
    logic [2:0]             status;
    logic                   wake_valid;
    logic [PID_FIELD_W-1:0] wake_pid;
  } rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic fetch;
    logic commit;
  } cst_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hit;
    logic scan_end;
    logic out_free;
  } cst_stat_t;

endpackage

// File: design/cst_ctrl.sv
// Sequencing state machine for the counting semaphore table.
`timescale 1ns / 1ps

module cst_ctrl
  import cst_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  cst_stat_t stat,
  output cst_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_FETCH = 2'd2;
  localparam logic [1:0] S_EXEC  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.hit || stat.scan_end) begin
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        // hold until the result register can take the item
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: design/cst_dpath.sv
// Slot memories, wait queues, key scan and result register.
`timescale 1ns / 1ps

module cst_dpath
  import cst_pkg::*;
#(
  parameter int NUM_SEMAPHORES = NUM_SEMAPHORES_DEF,
  parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF,
  parameter int PID_BITS       = PID_BITS_DEF,
  parameter int COUNT_BITS     = COUNT_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  cst_cmd_t  cmd,
  output cst_stat_t stat,
  input  req_t      req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output rsp_t      rsp
);

  localparam int SLOT_W = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;
  localparam int HEAD_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int LEN_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W  = LEN_W + 1;
  localparam int PW     = (PID_BITS < PID_FIELD_W) ? PID_BITS : PID_FIELD_W;
  localparam int CXW    = (COUNT_BITS > COUNT_FIELD_W) ? COUNT_BITS : COUNT_FIELD_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SEMAPHORES - 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Slot memories and wait queue store
  logic [31:0]           key_mem   [NUM_SEMAPHORES];
  logic [COUNT_BITS-1:0] count_mem [NUM_SEMAPHORES];
  logic [OPENERS_W-1:0]  open_mem  [NUM_SEMAPHORES];
  logic [HEAD_W-1:0]     head_mem  [NUM_SEMAPHORES];
  logic [LEN_W-1:0]      len_mem   [NUM_SEMAPHORES];
  logic [PW-1:0]         wq_mem    [NUM_SEMAPHORES][QUEUE_DEPTH];
  logic [NUM_SEMAPHORES-1:0] used;

  // Latched item
  logic [1:0]               cmd_r;
  logic [31:0]              key_r;
  logic [COUNT_FIELD_W-1:0] init_r;
  logic [PW-1:0]            pid_r;

  // Scan
  logic [SLOT_W-1:0] idx;
  logic              issued_all;
  logic              cmp_vld;
  logic [SLOT_W-1:0] cmp_idx;
  logic              issue;
  logic              hit_now;
  logic              found;
  logic [SLOT_W-1:0] sel;
  logic              free_found;
  logic [SLOT_W-1:0] free_idx;
  logic [SLOT_W-1:0] tgt;

  // Registered slot read
  logic [31:0]           rd_key;
  logic [COUNT_BITS-1:0] rd_count;
  logic [OPENERS_W-1:0]  rd_open;
  logic [HEAD_W-1:0]     rd_head;
  logic [LEN_W-1:0]      rd_len;
  logic [PW-1:0]         wp_q;

  // Update values
  logic [CXW-1:0]        init_x;
  logic [COUNT_BITS-1:0] init_clamp;
  logic [OPENERS_W-1:0]  open_dec;
  logic [SUM_W-1:0]      tail_sum;
  logic [SUM_W-1:0]      tail_full;
  logic [HEAD_W-1:0]     tail;
  logic [HEAD_W-1:0]     head_next;

  logic                  key_we, count_we, open_we, head_we, len_we, wq_we;
  logic                  used_set, used_clr;
  logic [COUNT_BITS-1:0] count_wd;
  logic [OPENERS_W-1:0]  open_wd;
  logic [HEAD_W-1:0]     head_wd;
  logic [LEN_W-1:0]      len_wd;
  logic [2:0]            st;
  logic                  wv;

  assign issue    = cmd.scan && !issued_all && !hit_now;
  assign hit_now  = cmp_vld && used[cmp_idx] && (rd_key == key_r);
  assign tgt      = found ? sel : free_idx;

  assign stat.hit      = hit_now;
  assign stat.scan_end = cmp_vld && (cmp_idx == LAST_SLOT);
  assign stat.out_free = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r  <= req.command;
      key_r  <= req.sem_key;
      init_r <= req.initial_count;
      pid_r  <= req.caller_pid[PW-1:0];
    end
    if (cmd.load) begin
      idx <= '0;
    end else if (issue) begin
      idx <= idx + SLOT_W'(1);
    end
    cmp_idx <= idx;
    if (hit_now) begin
      sel <= cmp_idx;
    end
    if (cmp_vld && !used[cmp_idx] && !free_found) begin
      free_idx <= cmp_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issued_all <= 1'b0;
      cmp_vld    <= 1'b0;
      found      <= 1'b0;
      free_found <= 1'b0;
    end else begin
      cmp_vld <= issue;
      if (cmd.load) begin
        issued_all <= 1'b0;
        found      <= 1'b0;
        free_found <= 1'b0;
      end else begin
        if (issue && (idx == LAST_SLOT)) begin
          issued_all <= 1'b1;
        end
        if (hit_now) begin
          found <= 1'b1;
        end
        if (cmp_vld && !used[cmp_idx]) begin
          free_found <= 1'b1;
        end
      end
    end
  end

  // Slot memories: one registered read, one write per cycle
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_key   <= key_mem[idx];
      rd_count <= count_mem[idx];
      rd_open  <= open_mem[idx];
      rd_head  <= head_mem[idx];
      rd_len   <= len_mem[idx];
    end
    if (cmd.commit && key_we) begin
      key_mem[tgt] <= key_r;
    end
    if (cmd.commit && count_we) begin
      count_mem[tgt] <= count_wd;
    end
    if (cmd.commit && open_we) begin
      open_mem[tgt] <= open_wd;
    end
    if (cmd.commit && head_we) begin
      head_mem[tgt] <= head_wd;
    end
    if (cmd.commit && len_we) begin
      len_mem[tgt] <= len_wd;
    end
  end

  // Wait queue store
  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      wp_q <= wq_mem[sel][rd_head];
    end
    if (cmd.commit && wq_we) begin
      wq_mem[sel][tail] <= pid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (cmd.commit) begin
      if (used_set) begin
        used[tgt] <= 1'b1;
      end
      if (used_clr) begin
        used[sel] <= 1'b0;
      end
    end
  end

  assign init_x     = CXW'(init_r);
  assign init_clamp = (init_x > CXW'(COUNT_MAX)) ? COUNT_MAX : init_x[COUNT_BITS-1:0];
  assign open_dec   = (rd_open != '0) ? rd_open - OPENERS_W'(1) : '0;
  assign tail_sum   = SUM_W'(rd_head) + SUM_W'(rd_len);
  assign tail_full  = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ? tail_sum - SUM_W'(QUEUE_DEPTH)
                                                        : tail_sum;
  assign tail       = tail_full[HEAD_W-1:0];
  assign head_next  = (rd_head == HEAD_W'(QUEUE_DEPTH - 1)) ? '0 : rd_head + HEAD_W'(1);

  always_comb begin
    key_we   = 1'b0;
    count_we = 1'b0;
    open_we  = 1'b0;
    head_we  = 1'b0;
    len_we   = 1'b0;
    wq_we    = 1'b0;
    used_set = 1'b0;
    used_clr = 1'b0;
    count_wd = rd_count;
    open_wd  = rd_open;
    head_wd  = rd_head;
    len_wd   = rd_len;
    st       = ST_OK;
    wv       = 1'b0;
    unique case (cmd_r)
      CMD_OPEN: begin
        if (found) begin
          open_we = 1'b1;
          open_wd = (rd_open == OPENERS_MAX) ? rd_open : rd_open + OPENERS_W'(1);
        end else if (free_found) begin
          used_set = 1'b1;
          key_we   = 1'b1;
          count_we = 1'b1;
          count_wd = init_clamp;
          open_we  = 1'b1;
          open_wd  = OPENERS_W'(1);
          head_we  = 1'b1;
          head_wd  = '0;
          len_we   = 1'b1;
          len_wd   = '0;
        end else begin
          st = ST_TABLE_FULL;
        end
      end
      CMD_CLOSE: begin
        if (!found) begin
          st = ST_NO_SEM;
        end else begin
          open_we = 1'b1;
          open_wd = open_dec;
          if (open_dec == '0) begin
            used_clr = 1'b1;
          end
        end
      end
      CMD_WAIT: begin
        if (!found) begin
          st = ST_NO_SEM;
        end else if (rd_count != '0) begin
          count_we = 1'b1;
          count_wd = rd_count - COUNT_BITS'(1);
        end else if (rd_len < LEN_W'(QUEUE_DEPTH)) begin
          wq_we  = 1'b1;
          len_we = 1'b1;
          len_wd = rd_len + LEN_W'(1);
          st     = ST_BLOCKED;
        end else begin
          st = ST_QUEUE_FULL;
        end
      end
      CMD_POST: begin
        if (!found) begin
          st = ST_NO_SEM;
        end else begin
          count_we = 1'b1;
          count_wd = (rd_count == COUNT_MAX) ? rd_count : rd_count + COUNT_BITS'(1);
          if (rd_len != '0) begin
            wv      = 1'b1;
            head_we = 1'b1;
            head_wd = head_next;
            len_we  = 1'b1;
            len_wd  = rd_len - LEN_W'(1);
          end
        end
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.commit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp.status     <= st;
      rsp.wake_valid <= wv;
      rsp.wake_pid   <= wv ? PID_FIELD_W'(wp_q) : '0;
    end
  end

endmodule

// File: design/counting_semaphore_table.sv
// Top level of the counting semaphore table: controller plus datapath.
// One item in flight; the next command is accepted in the cycle after the result is loaded.
// The key scan sets the time per item: one slot memory read and compare per cycle.
// Reset clears slot valid bits, the state machine and the result valid; no clearing pass.
`timescale 1ns / 1ps

module counting_semaphore_table
  import cst_pkg::*;
#(
  parameter int NUM_SEMAPHORES = NUM_SEMAPHORES_DEF,
  parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF,
  parameter int PID_BITS       = PID_BITS_DEF,
  parameter int COUNT_BITS     = COUNT_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  // command items
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  // result items
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  // Flow per item:
  //   IDLE  - take the command item, latch its fields, reset the scan.
  //   SCAN  - walk the slot memories one entry per cycle; the first used slot
  //           whose key matches stops the walk, and the lowest free slot seen
  //           on the way is kept for a create.
  //   FETCH - read the oldest waiter of the matched slot (used by post).
  //   EXEC  - once the result register is free, write the slot update and
  //           load the result. The result register lets the next command be
  //           taken while this result still waits for rsp_ready.

  cst_cmd_t  cmd;
  cst_stat_t stat;

  cst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cst_dpath #(
    .NUM_SEMAPHORES (NUM_SEMAPHORES),
    .QUEUE_DEPTH    (QUEUE_DEPTH),
    .PID_BITS       (PID_BITS),
    .COUNT_BITS     (COUNT_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

// File: sim/counting_semaphore_table_tb.sv
// Self-checking testbench for the counting semaphore table: scoreboard, command and result drivers.
`timescale 1ns / 1ps

module counting_semaphore_table_tb;
  import cst_pkg::*;

  localparam int NSEM         = NUM_SEMAPHORES_DEF;
  localparam int QDEPTH       = QUEUE_DEPTH_DEF;
  localparam int POOL_SIZE    = 20;   // more keys than slots, so the table can fill
  localparam int DIRECTED     = 21;
  localparam int RANDOM_ITEMS = 1650;
  localparam int TAIL_CYCLES  = NSEM + 8;

  localparam logic [COUNT_FIELD_W-1:0] COUNT_MAX =
    COUNT_FIELD_W'((64'd1 << COUNT_BITS_DEF) - 64'd1);
  localparam logic [PID_FIELD_W-1:0] PID_MASK =
    PID_FIELD_W'((32'd1 << PID_BITS_DEF) - 32'd1);

  // Mirror of the semaphore table plus the results it predicts, oldest first.
  class semaphore_scoreboard;
    bit                       slot_used   [NSEM];
    logic [31:0]              slot_key    [NSEM];
    logic [COUNT_FIELD_W-1:0] slot_count  [NSEM];
    logic [OPENERS_W-1:0]     slot_openers[NSEM];
    logic [PID_FIELD_W-1:0]   waiters     [NSEM*QDEPTH];
    int                       waiter_head [NSEM];
    int                       waiter_len  [NSEM];
    rsp_t                     expected_q[$];
    int                       fail_count;

    // Lookup takes the lowest used slot with a matching key.
    function int find_slot(logic [31:0] key);
      for (int i = 0; i < NSEM; i++)
        if (slot_used[i] && slot_key[i] == key) return i;
      return -1;
    endfunction

    function int openers_of(logic [31:0] key);
      int s;
      s = find_slot(key);
      return (s < 0) ? 0 : int'(slot_openers[s]);
    endfunction

    function bit first_used_key(output logic [31:0] key);
      key = '0;
      for (int i = 0; i < NSEM; i++)
        if (slot_used[i]) begin
          key = slot_key[i];
          return 1'b1;
        end
      return 1'b0;
    endfunction

    function void note_command(req_t cmd_in);
      rsp_t                   want;
      int                     s;
      int                     f;
      int                     pos;
      logic [PID_FIELD_W-1:0] pid;
      want = '0;
      pid  = cmd_in.caller_pid & PID_MASK;
      s    = find_slot(cmd_in.sem_key);
      if (cmd_in.command == CMD_OPEN) begin
        if (s >= 0) begin
          if (slot_openers[s] < OPENERS_MAX)
            slot_openers[s] = slot_openers[s] + OPENERS_W'(1);
        end else begin
          // new entry goes to the lowest free slot
          f = -1;
          for (int i = NSEM - 1; i >= 0; i--)
            if (!slot_used[i]) f = i;
          if (f < 0) begin
            want.status = ST_TABLE_FULL;
          end else begin
            slot_used[f]    = 1'b1;
            slot_key[f]     = cmd_in.sem_key;
            slot_count[f]   = (cmd_in.initial_count > COUNT_MAX) ? COUNT_MAX
                                                                 : cmd_in.initial_count;
            slot_openers[f] = OPENERS_W'(1);
            waiter_head[f]  = 0;
            waiter_len[f]   = 0;
          end
        end
      end else if (s < 0) begin
        want.status = ST_NO_SEM;
      end else if (cmd_in.command == CMD_CLOSE) begin
        if (slot_openers[s] != '0) slot_openers[s] = slot_openers[s] - OPENERS_W'(1);
        if (slot_openers[s] == '0) begin
          // last opener gone: waiters are dropped, never woken
          slot_used[s]   = 1'b0;
          waiter_len[s]  = 0;
          waiter_head[s] = 0;
        end
      end else if (cmd_in.command == CMD_WAIT) begin
        if (slot_count[s] != '0) begin
          slot_count[s] = slot_count[s] - COUNT_FIELD_W'(1);
        end else if (waiter_len[s] < QDEPTH) begin
          pos = s * QDEPTH + (waiter_head[s] + waiter_len[s]) % QDEPTH;
          waiters[pos]  = pid;
          waiter_len[s] = waiter_len[s] + 1;
          want.status   = ST_BLOCKED;
        end else begin
          want.status = ST_QUEUE_FULL;
        end
      end else begin
        if (slot_count[s] != COUNT_MAX) slot_count[s] = slot_count[s] + COUNT_FIELD_W'(1);
        if (waiter_len[s] > 0) begin
          pos = s * QDEPTH + waiter_head[s];
          want.wake_valid = 1'b1;
          want.wake_pid   = waiters[pos];
          waiter_head[s]  = (waiter_head[s] + 1) % QDEPTH;
          waiter_len[s]   = waiter_len[s] - 1;
        end
      end
      expected_q.push_back(want);
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (expected_q.size() == 0) begin
        $error("result with nothing outstanding: status %0d wake_valid %0d wake_pid %0d",
               got.status, got.wake_valid, got.wake_pid);
        fail_count++;
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        fail_count++;
      end
      if (got.wake_valid !== want.wake_valid) begin
        $error("wake_valid: expected %0d, got %0d", want.wake_valid, got.wake_valid);
        fail_count++;
      end
      if (got.wake_pid !== want.wake_pid) begin
        $error("wake_pid: expected %0d, got %0d", want.wake_pid, got.wake_pid);
        fail_count++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  semaphore_scoreboard board;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          items_sent     = 0;
  logic [31:0] key_pool [POOL_SIZE];

  counting_semaphore_table dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #5000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Result side: check on each accepted item, then redraw ready.
  initial begin
    rsp_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && rsp_ready) board.check_result(rsp);
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic [COUNT_FIELD_W-1:0] pick_count();
    int pick;
    pick = $urandom_range(3);
    if (pick == 0) return '0;
    if (pick == 1) return COUNT_FIELD_W'($urandom_range(1, 3));
    if (pick == 2) return '1;
    return COUNT_FIELD_W'($urandom);
  endfunction

  function automatic logic [31:0] pick_key();
    if ($urandom_range(9) == 0) return $urandom;
    return key_pool[$urandom_range(POOL_SIZE - 1)];
  endfunction

  function automatic logic [PID_FIELD_W-1:0] pick_pid();
    return PID_FIELD_W'($urandom);
  endfunction

  // Valid stays up from one item to the next unless an idle gap is drawn.
  task automatic send_command(input logic [1:0] cmd, input logic [31:0] key,
                              input logic [COUNT_FIELD_W-1:0] init,
                              input logic [PID_FIELD_W-1:0] pid);
    req_t item;
    item.command       = cmd;
    item.sem_key       = key;
    item.initial_count = init;
    item.caller_pid    = pid;
    if ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (!req_ready);
    board.note_command(item);
    items_sent++;
  endtask

  task automatic hold_until_drained();
    req_valid <= 1'b0;
    do @(posedge clk); while (board.expected_q.size() != 0);
  endtask

  task automatic mixed_traffic(input int count);
    logic [1:0] cmd;
    int         pick;
    repeat (count) begin
      pick = $urandom_range(3);
      if (pick == 0)      cmd = CMD_OPEN;
      else if (pick == 1) cmd = CMD_CLOSE;
      else if (pick == 2) cmd = CMD_WAIT;
      else                cmd = CMD_POST;
      send_command(cmd, pick_key(), pick_count(), pick_pid());
    end
  endtask

  // Open every pool key; once the slots run out, new keys see table full.
  task automatic fill_table();
    for (int i = 0; i < POOL_SIZE; i++)
      send_command(CMD_OPEN, key_pool[i], pick_count(), pick_pid());
  endtask

  // Fresh key with a small count, then waits past the count so callers queue up.
  // Interleaved posts and reissued waits move the queue head around the ring.
  task automatic wait_queue_run(input bit to_full);
    logic [31:0]              key;
    logic [COUNT_FIELD_W-1:0] init;
    int                       depth;
    key   = $urandom;
    init  = COUNT_FIELD_W'($urandom_range(2));
    depth = int'(init) + (to_full ? QDEPTH + 2 : int'($urandom_range(1, QDEPTH + 2)));
    send_command(CMD_OPEN, key, init, pick_pid());
    repeat (depth) begin
      if (!to_full && $urandom_range(4) == 0)
        send_command(CMD_POST, key, pick_count(), pick_pid());
      send_command(CMD_WAIT, key, pick_count(), pick_pid());
    end
    repeat ($urandom_range(1, depth)) begin
      send_command(CMD_POST, key, pick_count(), pick_pid());
      if ($urandom_range(1) == 0) send_command(CMD_WAIT, key, pick_count(), pick_pid());
    end
    if ($urandom_range(3) != 0) send_command(CMD_CLOSE, key, pick_count(), pick_pid());
  endtask

  // Open count pinned at its ceiling, then walked all the way back down.
  task automatic opener_saturation();
    logic [31:0] key;
    int          n;
    key = $urandom;
    repeat (int'(OPENERS_MAX) + 3) send_command(CMD_OPEN, key, pick_count(), pick_pid());
    send_command(CMD_POST, key, pick_count(), pick_pid());
    send_command(CMD_WAIT, key, pick_count(), pick_pid());
    n = board.openers_of(key);
    repeat (n + 1) send_command(CMD_CLOSE, key, pick_count(), pick_pid());
  endtask

  task automatic release_all();
    logic [31:0] key;
    while (board.first_used_key(key))
      send_command(CMD_CLOSE, key, pick_count(), pick_pid());
    send_command(CMD_CLOSE, pick_key(), pick_count(), pick_pid());
  endtask

  initial begin
    int pick;
    board = new;
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: unknown keys, blocking with duplicate pids, FIFO wake order,
    // close with waiters pending, count saturation, key and field extremes.
    send_command(CMD_CLOSE, '1, '0, '0);
    send_command(CMD_WAIT,  '0, '1, '1);
    send_command(CMD_POST,  '0, '0, '0);
    send_command(CMD_OPEN,  '0, '0, '0);
    send_command(CMD_WAIT,  '0, '0, '1);
    send_command(CMD_WAIT,  '0, '0, '1);
    send_command(CMD_WAIT,  '0, '0, '0);
    send_command(CMD_POST,  '0, '0, '0);
    send_command(CMD_POST,  '0, '1, '0);
    send_command(CMD_OPEN,  '0, '1, '1);
    send_command(CMD_CLOSE, '0, '0, '0);
    send_command(CMD_CLOSE, '0, '0, '0);   // frees entry, pid 0 dropped
    send_command(CMD_POST,  '0, '0, '0);
    send_command(CMD_OPEN,  '0, COUNT_FIELD_W'(5), '0);
    send_command(CMD_POST,  '0, '0, '0);
    send_command(CMD_OPEN,  '1, '1, '1);
    send_command(CMD_POST,  '1, '0, '0);   // already at max count
    send_command(CMD_WAIT,  '1, '0, '1);
    send_command(CMD_WAIT,  '0, '0, PID_FIELD_W'(8'h55));
    send_command(CMD_CLOSE, '1, '0, '0);
    send_command(CMD_CLOSE, '0, '1, '1);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      if (phase == 0) begin
        wait_queue_run(1'b1);
        opener_saturation();
        fill_table();
        release_all();
      end
      while (items_sent < DIRECTED + (phase + 1) * RANDOM_ITEMS / 4) begin
        pick = $urandom_range(19);
        if (pick < 7)       mixed_traffic($urandom_range(5, 30));
        else if (pick < 9)  fill_table();
        else if (pick < 17) wait_queue_run($urandom_range(3) == 0);
        else                release_all();
      end
      // sender holds off until every outstanding result is back
      hold_until_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
